// ===== sv/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Types and codes shared by the sorted key table and its channel interfaces.
// ----------------------------------------------------------------------------
package skt_pkg;

  typedef logic        [1:0]  kind_t;
  typedef logic        [1:0]  status_t;
  typedef logic signed [31:0] key_t;
  typedef logic        [31:0] tag_t;

  // one table entry as held in the table memory
  typedef struct packed {
    key_t key;
    tag_t tag;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_DELETE = 2'd1;
  localparam kind_t KIND_READ   = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

endpackage

// ===== sv/skt_in_if.sv =====
// ----------------------------------------------------------------------------
// skt_in_if
// Request channel: operation kind, key and tag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface skt_in_if;
  import skt_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  key_t  key;
  tag_t  tag;

  modport source (output valid, output kind, output key, output tag, input ready);
  modport sink   (input valid, input kind, input key, input tag, output ready);

endinterface

// ===== sv/skt_out_if.sv =====
// ----------------------------------------------------------------------------
// skt_out_if
// Result channel: status, entry key and tag, last flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface skt_out_if;
  import skt_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  key_t    entry_key;
  tag_t    entry_tag;
  logic    last;

  modport source (output valid, output status, output entry_key, output entry_tag,
                  output last, input ready);
  modport sink   (input valid, input status, input entry_key, input entry_tag,
                  input last, output ready);

endinterface

// ===== sv/skt_ram.sv =====
// ----------------------------------------------------------------------------
// skt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while re_i is low
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sorted_key_table.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table
// Bounded table of signed keys with tags, kept in descending key order.
// ----------------------------------------------------------------------------
// Requests arrive on in_i (kind, key, tag); results leave on out_o (status,
// entry_key, entry_tag, last). Both channels move a word when valid and ready
// are high at a rising edge. One request is worked at a time: in_i.ready is
// high only while the sequencer is idle.
// All work goes through one table RAM (one read, one write port, registered
// read) under a small sequencer, one entry per cycle unless the output stalls:
//   insert: on an empty table the entry goes straight to slot 0; a full table
//           answers status full
//   delete: every entry is read once, later ones move down
//   readout: one word per cycle while the receiver keeps up
// An insert scans from the tail, moving entries up until its slot is found.
// The result word sits in an output register, so the sequencer keeps going
// while it waits; when the receiver stalls the sequencer holds at the next
// word to send. Reset empties the table at once (entry count cleared, no
// clearing pass) and drops any pending result. Kind 3 is taken and dropped.
// ----------------------------------------------------------------------------
module sorted_key_table #(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  skt_in_if.sink    in_i,
  skt_out_if.source out_o
);
  import skt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_INS_PUT = 4'd3;
  localparam logic [3:0] S_DEL_RD  = 4'd4;
  localparam logic [3:0] S_DEL_CMP = 4'd5;
  localparam logic [3:0] S_RD_RD   = 4'd6;
  localparam logic [3:0] S_RD_OUT  = 4'd7;
  localparam logic [3:0] S_EMIT    = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          found_q, found_d;
  status_t       stat_q, stat_d;
  key_t          key_q;
  tag_t          tag_q;

  logic          out_valid_q;
  status_t       out_status_q;
  key_t          out_key_q;
  tag_t          out_tag_q;
  logic          out_last_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [EntryW-1:0] ram_rdata;
  entry_t        rd_ent;
  entry_t        new_ent;

  logic          out_free;
  logic          out_load;
  status_t       ld_status;
  key_t          ld_key;
  tag_t          ld_tag;
  logic          ld_last;
  logic          shift;
  logic          hit;
  logic          at_end;
  logic          in_acc;

  assign rd_ent   = ram_rdata;
  assign new_ent  = '{key: key_q, tag: tag_q};
  assign out_free = !out_valid_q || out_o.ready;
  assign at_end   = (idx_q == cnt_q - CW'(1));
  assign in_acc   = in_i.valid && in_i.ready;

  assign in_i.ready = (state_q == S_IDLE);

  skt_ram #(
    .WIDTH (EntryW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    found_d   = found_q;
    stat_d    = stat_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = new_ent;
    ram_re    = 1'b0;
    ram_raddr = idx_q[AW-1:0];
    out_load  = 1'b0;
    ld_status = stat_q;
    ld_key    = '0;
    ld_tag    = '0;
    ld_last   = 1'b1;
    // the head entry wins ties, later entries lose them
    shift     = (idx_q == '0) ? (key_q > rd_ent.key) : (key_q >= rd_ent.key);
    hit       = found_q || (rd_ent.key == key_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          unique case (in_i.kind)
            KIND_INSERT: begin
              if (cnt_q == CW'(DEPTH)) begin
                stat_d  = ST_FULL;
                state_d = S_EMIT;
              end else if (cnt_q == '0) begin
                state_d = S_INS_PUT;
              end else begin
                idx_d   = cnt_q - CW'(1);
                state_d = S_INS_RD;
              end
            end
            KIND_DELETE: begin
              if (cnt_q == '0) begin
                stat_d  = ST_EMPTY;
                state_d = S_EMIT;
              end else begin
                idx_d   = '0;
                found_d = 1'b0;
                state_d = S_DEL_RD;
              end
            end
            KIND_READ: begin
              if (cnt_q == '0) begin
                stat_d  = ST_EMPTY;
                state_d = S_EMIT;
              end else begin
                idx_d   = '0;
                state_d = S_RD_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_INS_RD: begin
        ram_re  = 1'b1;
        state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_q + CW'(1));
        if (shift) begin
          ram_wdata = rd_ent;
          if (idx_q == '0) begin
            state_d = S_INS_PUT;
          end else begin
            idx_d     = idx_q - CW'(1);
            ram_re    = 1'b1;
            ram_raddr = AW'(idx_q - CW'(1));
          end
        end else begin
          cnt_d   = cnt_q + CW'(1);
          stat_d  = ST_OK;
          state_d = S_EMIT;
        end
      end
      S_INS_PUT: begin
        ram_we  = 1'b1;
        cnt_d   = cnt_q + CW'(1);
        stat_d  = ST_OK;
        state_d = S_EMIT;
      end
      S_DEL_RD: begin
        ram_re  = 1'b1;
        state_d = S_DEL_CMP;
      end
      S_DEL_CMP: begin
        // once the match is passed, every later entry moves down one slot
        if (found_q) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(idx_q - CW'(1));
          ram_wdata = rd_ent;
        end
        found_d = hit;
        if (at_end) begin
          if (hit) begin
            cnt_d  = cnt_q - CW'(1);
            stat_d = ST_OK;
          end else begin
            stat_d = ST_NOT_FOUND;
          end
          state_d = S_EMIT;
        end else begin
          idx_d     = idx_q + CW'(1);
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_q + CW'(1));
        end
      end
      S_RD_RD: begin
        ram_re  = 1'b1;
        state_d = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = ST_OK;
          ld_key    = rd_ent.key;
          ld_tag    = rd_ent.tag;
          ld_last   = at_end;
          if (at_end) begin
            state_d = S_IDLE;
          end else begin
            idx_d     = idx_q + CW'(1);
            ram_re    = 1'b1;
            ram_raddr = AW'(idx_q + CW'(1));
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      stat_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      stat_q  <= stat_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= in_i.key;
      tag_q <= in_i.tag;
    end
    if (out_load) begin
      out_status_q <= ld_status;
      out_key_q    <= ld_key;
      out_tag_q    <= ld_tag;
      out_last_q   <= ld_last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.entry_key = out_key_q;
  assign out_o.entry_tag = out_tag_q;
  assign out_o.last      = out_last_q;

  // the entry count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above table depth");

  // table writes stay inside the live region plus the one slot being opened
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ({1'b0, ram_waddr} <= {1'b0, cnt_q}))
    else $error("table write beyond live entries");

  // the entry count moves by at most one per cycle
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      ((cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q == $past(cnt_q) - CW'(1))))
    else $error("entry count jumped");

  // a word that is not the last one only comes from a readout with status ok
  a_mid_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (out_status_q == ST_OK))
    else $error("non-final word with error status");

endmodule

// ===== dv/tb_sorted_key_table.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_key_table
// Self-checking bench for the sorted key table: a short directed table, then
// random insert, delete, readout and unused-kind traffic. Every result word is
// compared with a fixed answer or a shadow copy of the table kept in the bench.
// The sender runs in bursts, and the receiver stalls on its own pattern, with
// one long hold-off.
module tb_sorted_key_table;
  import skt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 16;
  localparam int RAND_ITEMS   = 144;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 3 * DEPTH + 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DIR_ROWS     = 26;

  localparam kind_t KIND_UNUSED = 2'd3;
  localparam key_t  KEY_MIN     = 32'h8000_0000;
  localparam key_t  KEY_MAX     = 32'h7fff_ffff;

  typedef struct packed {
    status_t status;
    key_t    entry_key;
    tag_t    entry_tag;
    logic    last;
  } reply_word_t;

  // typed rows carry a fixed single-word answer, the others go to the shadow
  typedef struct {
    kind_t   kind;
    key_t    key;
    tag_t    tag;
    bit      typed;
    status_t status;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  skt_in_if  req_if ();
  skt_out_if rsp_if ();

  sorted_key_table #(
    .DEPTH (DEPTH)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the table contents, in descending key order
  key_t shadow_keys [DEPTH];
  tag_t shadow_tags [DEPTH];
  int   shadow_count;

  reply_word_t reply_words_q [$];

  int errors = 0;
  int words_seen = 0;
  int cycle_count = 0;
  int n_ins, n_full, n_del, n_miss, n_read, n_unused;
  int burst_left;
  logic long_hold_go;
  bit   long_hold_done = 1'b0;

  stim_row_t dir_rows [DIR_ROWS];

  task automatic shadow_table_op(input kind_t k, input key_t key, input tag_t tag,
                                 input bit emit);
    int pos;
    status_t st;
    case (k)
      KIND_INSERT: begin
        n_ins++;
        if (shadow_count >= DEPTH) begin
          st = ST_FULL;
          n_full++;
        end else begin
          // a tie with the head key lands behind it, later ties land in front
          if (shadow_count == 0 || key > shadow_keys[0]) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < shadow_count && shadow_keys[pos] > key) pos++;
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_tags[i] = shadow_tags[i-1];
          end
          shadow_keys[pos] = key;
          shadow_tags[pos] = tag;
          shadow_count++;
          st = ST_OK;
        end
        if (emit) reply_words_q.push_back('{st, 32'h0, 32'h0, 1'b1});
      end
      KIND_DELETE: begin
        n_del++;
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] != key) pos++;
        if (shadow_count == 0) begin
          st = ST_EMPTY;
        end else if (pos >= shadow_count) begin
          st = ST_NOT_FOUND;
          n_miss++;
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_tags[i] = shadow_tags[i+1];
          end
          shadow_count--;
          st = ST_OK;
        end
        if (emit) reply_words_q.push_back('{st, 32'h0, 32'h0, 1'b1});
      end
      KIND_READ: begin
        n_read++;
        if (emit) begin
          if (shadow_count == 0) begin
            reply_words_q.push_back('{ST_EMPTY, 32'h0, 32'h0, 1'b1});
          end else begin
            for (int i = 0; i < shadow_count; i++)
              reply_words_q.push_back('{ST_OK, shadow_keys[i], shadow_tags[i],
                                        i == shadow_count - 1});
          end
        end
      end
      default: n_unused++;
    endcase
  endtask

  task automatic send_req(input kind_t k, input key_t key, input tag_t tag,
                          input bit typed, input status_t st);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.kind  <= k;
    req_if.key   <= key;
    req_if.tag   <= tag;
    do @(posedge clk_i); while (!req_if.ready);
    shadow_table_op(k, key, tag, !typed);
    if (typed) reply_words_q.push_back('{st, 32'h0, 32'h0, 1'b1});
  endtask

  function automatic key_t pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return key_t'(int'($urandom_range(0, 6)) - 3);
    if (r == 4) return KEY_MIN;
    if (r == 5) return KEY_MAX;
    return key_t'($urandom);
  endfunction

  // receiver pacing in randomly chosen modes
  initial begin : rx_pace
    int unsigned mode, span;
    logic [7:0] mask;
    rsp_if.ready = 1'b0;
    mode = 0;
    span = 0;
    mask = 8'hb5;
    forever begin
      @(posedge clk_i);
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 96);
        mask = 8'($urandom) | 8'h01;
      end
      span--;
      case (mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= 1'($urandom_range(0, 1));
        2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          rsp_if.ready <= mask[0];
          mask = {mask[6:0], mask[7]};
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    reply_word_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      words_seen++;
      if (reply_words_q.size() == 0) begin
        $display("%0t: unexpected word, status %0d key %0d tag %h last %0b", $time,
                 rsp_if.status, rsp_if.entry_key, rsp_if.entry_tag, rsp_if.last);
        errors++;
      end else begin
        want = reply_words_q.pop_front();
        if (rsp_if.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d got %0d", $time,
                   want.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.entry_key !== want.entry_key) begin
          $display("%0t: entry_key mismatch, expected %0d got %0d", $time,
                   want.entry_key, rsp_if.entry_key);
          errors++;
        end
        if (rsp_if.entry_tag !== want.entry_tag) begin
          $display("%0t: entry_tag mismatch, expected %h got %h", $time,
                   want.entry_tag, rsp_if.entry_tag);
          errors++;
        end
        if (rsp_if.last !== want.last) begin
          $display("%0t: last mismatch, expected %0b got %0b", $time,
                   want.last, rsp_if.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, reply_words_q.size());
      $display("sorted_key_table verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    kind_t k;
    key_t key;
    tag_t tag;
    int unsigned roll, ins_cut, del_cut;
    bit fill_phase;

    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.kind  = KIND_INSERT;
    req_if.key   = '0;
    req_if.tag   = '0;
    long_hold_go = 1'b0;
    burst_left   = 0;
    shadow_count = 0;
    n_ins = 0; n_full = 0; n_del = 0; n_miss = 0; n_read = 0; n_unused = 0;

    dir_rows = '{
      '{KIND_READ,   0,            32'h0,         1'b1, ST_EMPTY},
      '{KIND_DELETE, 0,            32'h0,         1'b1, ST_EMPTY},
      '{KIND_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b0, ST_OK},
      '{KIND_INSERT, 0,            32'h0,         1'b1, ST_OK},
      '{KIND_INSERT, 0,            32'hffff_ffff, 1'b1, ST_OK},
      '{KIND_INSERT, KEY_MIN,      32'haaaa_5555, 1'b1, ST_OK},
      '{KIND_INSERT, KEY_MAX,      32'h5555_aaaa, 1'b1, ST_OK},
      '{KIND_INSERT, 0,            32'h1,         1'b1, ST_OK},
      '{KIND_READ,   0,            32'h0,         1'b0, ST_OK},
      '{KIND_DELETE, 5,            32'h0,         1'b1, ST_NOT_FOUND},
      '{KIND_DELETE, 0,            32'h0,         1'b1, ST_OK},
      '{KIND_INSERT, KEY_MAX,      32'h2,         1'b1, ST_OK},
      '{KIND_INSERT, 100,          32'h100,       1'b0, ST_OK},
      '{KIND_INSERT, -100,         32'h200,       1'b0, ST_OK},
      '{KIND_INSERT, 7,            32'h300,       1'b0, ST_OK},
      '{KIND_INSERT, -7,           32'h400,       1'b0, ST_OK},
      '{KIND_INSERT, 1,            32'h500,       1'b0, ST_OK},
      '{KIND_INSERT, -1,           32'h600,       1'b0, ST_OK},
      '{KIND_INSERT, 50,           32'h700,       1'b0, ST_OK},
      '{KIND_INSERT, 0,            32'h800,       1'b0, ST_OK},
      '{KIND_INSERT, 32'h1234_5678, 32'h900,      1'b0, ST_OK},
      '{KIND_INSERT, 32'hfedc_ba98, 32'ha00,      1'b0, ST_OK},
      '{KIND_INSERT, 0,            32'hdead_beef, 1'b0, ST_OK},
      '{KIND_INSERT, 3,            32'h0,         1'b1, ST_FULL},
      '{KIND_READ,   0,            32'h0,         1'b0, ST_OK},
      '{KIND_DELETE, KEY_MIN,      32'h0,         1'b1, ST_OK}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_req(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].tag,
               dir_rows[i].typed, dir_rows[i].status);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // long receiver hold-off while requests keep coming
      if (n == 30) long_hold_go <= 1'b1;
      fill_phase = ((n / 40) % 2) == 0;
      ins_cut = fill_phase ? 55 : 20;
      del_cut = ins_cut + (fill_phase ? 20 : 55);
      roll = $urandom_range(0, 99);
      if (roll < ins_cut) k = KIND_INSERT;
      else if (roll < del_cut) k = KIND_DELETE;
      else if (roll < del_cut + 20) k = KIND_READ;
      else k = KIND_UNUSED;

      if (k == KIND_DELETE && shadow_count > 0 && $urandom_range(0, 3) != 0)
        key = shadow_keys[$urandom_range(0, shadow_count - 1)];
      else
        key = pick_key();
      case ($urandom_range(0, 7))
        0: tag = '0;
        1: tag = '1;
        default: tag = $urandom;
      endcase
      send_req(k, key, tag, 1'b0, ST_OK);
    end
    req_if.valid <= 1'b0;

    while (reply_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d inserts (%0d refused on a full table), %0d deletes (%0d misses),",
             n_ins, n_full, n_del, n_miss);
    $display("%0d readouts and %0d unused-kind words; %0d result words checked",
             n_read, n_unused, words_seen);
    if (errors == 0) begin
      $display("sorted_key_table verification clean");
    end else begin
      $display("sorted_key_table verification failed");
    end
    $finish;
  end

endmodule

// ===== sorted_key_table.f =====
sv/skt_pkg.sv
sv/skt_in_if.sv
sv/skt_out_if.sv
sv/skt_ram.sv
sv/sorted_key_table.sv
dv/tb_sorted_key_table.sv
